// ----- rtl/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Field widths, microcode control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int BASE_W = 31;
  localparam int EXP_W  = 32;
  localparam int MOD_W  = 16;

  // One counter serves the base reduction and the multiplier bit loops.
  localparam int CNT_W  = (BASE_W > MOD_W) ? $clog2(BASE_W) : $clog2(MOD_W);
  localparam int ECNT_W = (EXP_W > 1) ? $clog2(EXP_W) : 1;
  localparam int PC_W   = 4;

  typedef logic [BASE_W-1:0] base_t;
  typedef logic [EXP_W-1:0]  exp_t;
  typedef logic [MOD_W-1:0]  res_t;

  // Datapath operations.
  localparam logic [2:0] OP_BINIT = 3'd0;
  localparam logic [2:0] OP_BSTEP = 3'd1;
  localparam logic [2:0] OP_TEST  = 3'd2;
  localparam logic [2:0] OP_MINIT = 3'd3;
  localparam logic [2:0] OP_MSTEP = 3'd4;
  localparam logic [2:0] OP_NEXT  = 3'd5;
  localparam logic [2:0] OP_DONE  = 3'd6;

  // Operand select: the multiplicand on OP_MINIT, the destination on OP_MSTEP.
  localparam logic SEL_ACC = 1'b0;
  localparam logic SEL_SQ  = 1'b1;

  // Jump conditions.
  localparam logic [1:0] JMP_NONE  = 2'd0;
  localparam logic [1:0] JMP_CNT   = 2'd1;
  localparam logic [1:0] JMP_EBIT0 = 2'd2;
  localparam logic [1:0] JMP_ECNT  = 2'd3;

  typedef struct packed {
    logic [2:0]      op;
    logic            sel;
    logic [1:0]      jmp;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // Right-to-left square-and-multiply program.
  function automatic ctrl_t program_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_BINIT, sel: SEL_SQ,  jmp: JMP_NONE,  target: 4'd0};
      4'd1:    w = '{op: OP_BSTEP, sel: SEL_SQ,  jmp: JMP_CNT,   target: 4'd1};
      4'd2:    w = '{op: OP_TEST,  sel: SEL_SQ,  jmp: JMP_EBIT0, target: 4'd5};
      4'd3:    w = '{op: OP_MINIT, sel: SEL_ACC, jmp: JMP_NONE,  target: 4'd0};
      4'd4:    w = '{op: OP_MSTEP, sel: SEL_ACC, jmp: JMP_CNT,   target: 4'd4};
      4'd5:    w = '{op: OP_MINIT, sel: SEL_SQ,  jmp: JMP_NONE,  target: 4'd0};
      4'd6:    w = '{op: OP_MSTEP, sel: SEL_SQ,  jmp: JMP_CNT,   target: 4'd6};
      4'd7:    w = '{op: OP_NEXT,  sel: SEL_SQ,  jmp: JMP_ECNT,  target: 4'd2};
      default: w = '{op: OP_DONE,  sel: SEL_SQ,  jmp: JMP_NONE,  target: 4'd0};
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/mexp_in_if.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation input channel
// Valid/ready channel carrying one base and one exponent per item.
// ----------------------------------------------------------------------------
interface mexp_in_if;
  logic           valid;
  logic           ready;
  mexp_pkg::base_t base_value;
  mexp_pkg::exp_t  exponent;

  modport source (output valid, output base_value, output exponent, input ready);
  modport sink   (input valid, input base_value, input exponent, output ready);
endinterface

// ----- rtl/mexp_out_if.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation output channel
// Valid/ready channel carrying one power result per item.
// ----------------------------------------------------------------------------
interface mexp_out_if;
  logic           valid;
  logic           ready;
  mexp_pkg::res_t power_result;

  modport source (output valid, output power_result, input ready);
  modport sink   (input valid, input power_result, output ready);
endinterface

// ----- rtl/modular_exponentiation_top.sv -----
// ----------------------------------------------------------------------------
// Modular exponentiation
// Computes base_value^exponent mod modulus with a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage: write the modulus through cfg_we/cfg_data while the block is idle;
// it resets to 2. Items arrive on in_ch and each gives exactly one result
// on out_ch, both valid/ready channels, an item moving when valid and ready
// are high at a rising edge.
// One item is processed at a time. After acceptance a sequencer steps through
// a small program: a bit-serial reduction of the base, then for each of the
// 32 exponent bits a test, an optional multiply into the accumulator and a
// squaring, each multiply running on an interleaved shift-add modular
// multiplier. The result sits in an output register, so a new item is
// accepted while the previous result still waits. If the receiver stalls
// past the end of the next item, the sequencer holds on its last step until
// the register frees. Synchronous reset clears the sequencer and the output
// valid and sets the modulus to 2. A modulus of 0 or 1 gives a result of 0.
// ----------------------------------------------------------------------------
module modular_exponentiation_top (
  input  logic                     clk,
  input  logic                     rst,
  mexp_in_if.sink                  in_ch,
  mexp_out_if.source               out_ch,
  input  logic                     cfg_we,
  input  logic [mexp_pkg::MOD_W-1:0] cfg_data
);

  localparam int MW = mexp_pkg::MOD_W;

  logic [MW-1:0] modulus;

  logic busy;
  logic [mexp_pkg::PC_W-1:0] pc;
  mexp_pkg::ctrl_t cw;

  mexp_pkg::base_t base_q;
  mexp_pkg::exp_t  exp_q;
  logic [mexp_pkg::CNT_W-1:0]  cnt;
  logic [mexp_pkg::ECNT_W-1:0] ecnt;

  logic [MW-1:0] acc;
  logic [MW-1:0] sq;
  logic [MW-1:0] mx;
  logic [MW-1:0] my;
  logic [MW-1:0] r;

  logic [MW+1:0] addend;
  logic [MW+1:0] t0;
  logic [MW+1:0] t1;
  logic [MW+1:0] t2;
  logic [MW+1:0] mod_ext;
  logic [MW-1:0] r_next;

  logic out_valid;
  logic [MW-1:0] out_data;
  logic out_free;
  logic jump;
  logic done_fire;

  assign cw = mexp_pkg::program_rom(pc);

  assign in_ch.ready         = !busy;
  assign out_ch.valid        = out_valid;
  assign out_ch.power_result = out_data;
  assign out_free            = !out_valid || out_ch.ready;
  assign done_fire           = busy && (cw.op == mexp_pkg::OP_DONE) && out_free;

  // One shared step: r <- (2r + addend) mod m. The addend is a base bit while
  // reducing the base, or the multiplicand when the multiplier's top bit is set.
  // Since r and the multiplicand stay below m, two subtractions suffice.
  always_comb begin
    mod_ext = {2'b00, modulus};
    if (cw.op == mexp_pkg::OP_BSTEP) begin
      addend = {{(MW+1){1'b0}}, base_q[cnt]};
    end else if (my[MW-1]) begin
      addend = {2'b00, mx};
    end else begin
      addend = '0;
    end
    t0 = {1'b0, r, 1'b0} + addend;
    t1 = (t0 >= mod_ext) ? t0 - mod_ext : t0;
    t2 = (t1 >= mod_ext) ? t1 - mod_ext : t1;
    r_next = t2[MW-1:0];
  end

  always_comb begin
    case (cw.jmp)
      mexp_pkg::JMP_CNT:   jump = (cnt != '0);
      mexp_pkg::JMP_EBIT0: jump = !exp_q[0];
      mexp_pkg::JMP_ECNT:  jump = (ecnt != '0);
      default:             jump = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MW'(2);
    end else if (cfg_we) begin
      modulus <= cfg_data;
    end
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc   <= '0;
    end else if (!busy) begin
      if (in_ch.valid) begin
        busy <= 1'b1;
        pc   <= '0;
      end
    end else if (cw.op == mexp_pkg::OP_DONE) begin
      if (out_free) begin
        busy <= 1'b0;
        pc   <= '0;
      end
    end else if (jump) begin
      pc <= cw.target;
    end else begin
      pc <= pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_data <= (modulus < MW'(2)) ? '0 : acc;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (in_ch.valid) begin
        base_q <= in_ch.base_value;
        exp_q  <= in_ch.exponent;
      end
    end else begin
      case (cw.op)
        mexp_pkg::OP_BINIT: begin
          r    <= '0;
          acc  <= MW'(1);
          cnt  <= mexp_pkg::CNT_W'(mexp_pkg::BASE_W - 1);
          ecnt <= mexp_pkg::ECNT_W'(mexp_pkg::EXP_W - 1);
        end
        mexp_pkg::OP_BSTEP: begin
          r   <= r_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            sq <= r_next;
          end
        end
        mexp_pkg::OP_MINIT: begin
          r   <= '0;
          mx  <= (cw.sel == mexp_pkg::SEL_ACC) ? acc : sq;
          my  <= sq;
          cnt <= mexp_pkg::CNT_W'(MW - 1);
        end
        mexp_pkg::OP_MSTEP: begin
          r   <= r_next;
          my  <= {my[MW-2:0], 1'b0};
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            if (cw.sel == mexp_pkg::SEL_ACC) begin
              acc <= r_next;
            end else begin
              sq <= r_next;
            end
          end
        end
        mexp_pkg::OP_NEXT: begin
          exp_q <= exp_q >> 1;
          ecnt  <= ecnt - 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base/exponent items into the block, predicts each power mod the
// configured modulus and checks every result in order, with random idling
// on both channels, two long output hold-offs and several modulus settings.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int NUM_DIR     = 22;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 65;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AT_A   = 120;
  localparam int HOLD_AT_B   = 450;
  localparam int TAIL_CYCLES = 1300;

  typedef struct packed {
    logic            set_mod;
    mexp_pkg::res_t  mod_val;
    mexp_pkg::base_t base_val;
    mexp_pkg::exp_t  exp_val;
    logic            known;
    mexp_pkg::res_t  want;
  } dir_row_t;

  // Rows with known set carry a result that follows directly from the
  // modulus: zero exponents, zero bases, degenerate moduli and small groups.
  dir_row_t dir_tab [0:NUM_DIR-1] = '{
    '{1'b0, 16'd0,     31'd3,          32'd1,          1'b1, 16'd1},
    '{1'b0, 16'd0,     31'd0,          32'd0,          1'b1, 16'd1},
    '{1'b0, 16'd0,     31'h7FFFFFFF,   32'hFFFFFFFF,   1'b1, 16'd1},
    '{1'b1, 16'hFFFF,  31'h7FFFFFFF,   32'hFFFFFFFF,   1'b0, 16'd0},
    '{1'b0, 16'd0,     31'd0,          32'd5,          1'b1, 16'd0},
    '{1'b0, 16'd0,     31'd12345,      32'd0,          1'b1, 16'd1},
    '{1'b0, 16'd0,     31'd1,          32'hFFFFFFFF,   1'b1, 16'd1},
    '{1'b0, 16'd0,     31'd65535,      32'd7,          1'b1, 16'd0},
    '{1'b0, 16'd0,     31'd65534,      32'd2,          1'b1, 16'd1},
    '{1'b0, 16'd0,     31'd65534,      32'd3,          1'b1, 16'd65534},
    '{1'b1, 16'd0,     31'd5,          32'd3,          1'b1, 16'd0},
    '{1'b0, 16'd0,     31'd0,          32'd0,          1'b1, 16'd0},
    '{1'b1, 16'd1,     31'd7,          32'd0,          1'b1, 16'd0},
    '{1'b0, 16'd0,     31'h7FFFFFFF,   32'hFFFFFFFF,   1'b1, 16'd0},
    '{1'b1, 16'd65521, 31'd2,          32'd65520,      1'b1, 16'd1},
    '{1'b0, 16'd0,     31'd3,          32'h80000000,   1'b0, 16'd0},
    '{1'b0, 16'd0,     31'h2AAAAAAA,   32'h55555555,   1'b0, 16'd0},
    '{1'b0, 16'd0,     31'h55555555,   32'hAAAAAAAA,   1'b0, 16'd0},
    '{1'b1, 16'd23,    31'd5,          32'd6,          1'b1, 16'd8},
    '{1'b0, 16'd0,     31'd5,          32'd15,         1'b1, 16'd19},
    '{1'b1, 16'd3,     31'd2,          32'd1,          1'b1, 16'd2},
    '{1'b0, 16'd0,     31'd2,          32'd2,          1'b1, 16'd1}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  mexp_pkg::res_t cfg_data;

  mexp_in_if  in_ch ();
  mexp_out_if out_ch ();

  modular_exponentiation_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  mexp_pkg::res_t power_q [$];
  mexp_pkg::res_t cur_mod = 16'd2;
  int   mismatch_cnt = 0;
  int   powers_seen  = 0;
  int   cycle_cnt    = 0;
  bit   src_idle     = 1'b1;
  bit   snk_idle     = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Right-to-left square-and-multiply; moduli below two give zero.
  function automatic mexp_pkg::res_t modpow(input mexp_pkg::base_t b,
                                            input mexp_pkg::exp_t e,
                                            input mexp_pkg::res_t m);
    longint unsigned acc;
    longint unsigned sq;
    longint unsigned mm;
    int i;
    mm = m;
    if (mm < 2) return '0;
    acc = 1 % mm;
    sq  = b % mm;
    for (i = 0; i < mexp_pkg::EXP_W; i++) begin
      if (e[i]) acc = (acc * sq) % mm;
      sq = (sq * sq) % mm;
    end
    return mexp_pkg::res_t'(acc);
  endfunction

  task automatic offer(input mexp_pkg::base_t b, input mexp_pkg::exp_t e,
                       input logic known, input mexp_pkg::res_t want);
    int gap;
    gap = src_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.base_value <= b;
    in_ch.exponent   <= e;
    do @(posedge clk); while (!in_ch.ready);
    power_q.push_back(known ? want : modpow(b, e, cur_mod));
  endtask

  // The modulus may only change while nothing is in flight.
  task automatic write_modulus(input mexp_pkg::res_t m);
    in_ch.valid <= 1'b0;
    while (power_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we  <= 1'b0;
    cur_mod = m;
  endtask

  initial begin : stimulus
    int              r;
    int              ph;
    int              k;
    mexp_pkg::res_t  m;
    mexp_pkg::base_t b;
    mexp_pkg::exp_t  e;
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.base_value <= '0;
    in_ch.exponent   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < NUM_DIR; r++) begin
      if (dir_tab[r].set_mod) write_modulus(dir_tab[r].mod_val);
      offer(dir_tab[r].base_val, dir_tab[r].exp_val, dir_tab[r].known, dir_tab[r].want);
    end

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       m = mexp_pkg::res_t'($urandom_range(2, 65535));
        1:       m = 16'hFFFF;
        2:       m = 16'd2;
        3:       m = mexp_pkg::res_t'($urandom_range(2, 255));
        4:       m = mexp_pkg::res_t'($urandom_range(0, 1));
        5:       m = 16'd65521;
        6:       m = mexp_pkg::res_t'($urandom_range(256, 65535));
        default: m = mexp_pkg::res_t'($urandom_range(0, 65535));
      endcase
      write_modulus(m);
      // One phase runs both channels flat out; the rest idle at random.
      src_idle = (ph != 1) && ($urandom_range(0, 3) != 0);
      snk_idle = (ph != 1) && ($urandom_range(0, 3) != 0);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        case ($urandom_range(0, 9)) inside
          0:       b = '0;
          1:       b = mexp_pkg::base_t'(1);
          2:       b = (m == 0) ? '0 : mexp_pkg::base_t'(m) - 1'b1;
          3:       b = mexp_pkg::base_t'(m) * mexp_pkg::base_t'($urandom_range(0, 1000));
          [4:5]:   b = mexp_pkg::base_t'($urandom_range(0, 300));
          default: b = mexp_pkg::base_t'($urandom());
        endcase
        case ($urandom_range(0, 9))
          0:       e = '0;
          1:       e = '1;
          2:       e = mexp_pkg::exp_t'($urandom_range(0, 40));
          3:       e = mexp_pkg::exp_t'(1) << $urandom_range(0, mexp_pkg::EXP_W - 1);
          default: e = mexp_pkg::exp_t'($urandom());
        endcase
        offer(b, e, 1'b0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (power_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side: random stalls per item, plus two long hold-offs that let
  // the block fill up and push back on its input.
  initial begin : result_sink
    int             gap;
    mexp_pkg::res_t want;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (powers_seen == HOLD_AT_A || powers_seen == HOLD_AT_B) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = snk_idle ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      if (power_q.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: power_result expected none, actual %0d", $time, out_ch.power_result);
      end else begin
        want = power_q.pop_front();
        if (out_ch.power_result !== want) begin
          mismatch_cnt++;
          $display("%0t: power_result expected %0d, actual %0d",
                   $time, want, out_ch.power_result);
        end
      end
      powers_seen++;
    end
  end

endmodule
